### sv/rotor_vector_rotate_core_assert.svh
// Assertion macros for the rotor vector rotate core
`ifndef ROTOR_VECTOR_ROTATE_CORE_ASSERT_SVH
`define ROTOR_VECTOR_ROTATE_CORE_ASSERT_SVH

// Implication in the same cycle
`define RVR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles
`define RVR_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

### sv/rvr_pkg.sv
// Shared constants and register codes for the rotor vector rotate core
`timescale 1ns / 1ps

package rvr_pkg;

    localparam int FRAC_BITS = 14;
    localparam int VEC_WIDTH = 16;
    localparam int ROT_WIDTH = 16;
    localparam int OUT_WIDTH = VEC_WIDTH + 1;

    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 4;

    localparam int PROD1_W = VEC_WIDTH + ROT_WIDTH;
    localparam int SUM1_W  = PROD1_W + 2;
    localparam int Q_W     = (SUM1_W - FRAC_BITS > 2) ? SUM1_W - FRAC_BITS : 2;
    localparam int PROD2_W = Q_W + ROT_WIDTH;
    localparam int SUM2_W  = PROD2_W + 2;
    localparam int R_W     = (SUM2_W - FRAC_BITS > 2) ? SUM2_W - FRAC_BITS : 2;
    localparam int SAT_W   = ((R_W > OUT_WIDTH) ? R_W : OUT_WIDTH) + 1;

    localparam int LATENCY = 4;

    localparam logic signed [ROT_WIDTH-1:0] ROTOR_ONE = ROT_WIDTH'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        REG_SCALAR = 2'd0,
        REG_YZ     = 2'd1,
        REG_ZX     = 2'd2,
        REG_XY     = 2'd3
    } reg_index_t;

endpackage

### sv/rotor_vector_rotate_core.sv
// Throughput: one vector per clock through four register stages: two multiply banks of
// twelve products (16 by 16, then 20 by 16 bits), each followed by a sum, round and (last)
// saturate stage. busy stays low; done is a one-cycle strobe and the receiver cannot stall it.
// Reset clears the valid pipeline and loads the identity rotor (scalar 1.0).
`timescale 1ns / 1ps

module rotor_vector_rotate_core
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [rvr_pkg::VEC_WIDTH-1:0]   vec_x,
    input  logic signed [rvr_pkg::VEC_WIDTH-1:0]   vec_y,
    input  logic signed [rvr_pkg::VEC_WIDTH-1:0]   vec_z,
    output logic                                   done,
    output logic signed [rvr_pkg::OUT_WIDTH-1:0]   out_x,
    output logic signed [rvr_pkg::OUT_WIDTH-1:0]   out_y,
    output logic signed [rvr_pkg::OUT_WIDTH-1:0]   out_z,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [rvr_pkg::ADDR_WIDTH-1:0]         paddr,
    input  logic [rvr_pkg::DATA_WIDTH-1:0]         pwdata,
    output logic [rvr_pkg::DATA_WIDTH-1:0]         prdata,
    output logic                                   pready
);

    localparam int PW1 = rvr_pkg::PROD1_W;
    localparam int SW1 = rvr_pkg::SUM1_W;
    localparam int QW  = rvr_pkg::Q_W;
    localparam int PW2 = rvr_pkg::PROD2_W;
    localparam int SW2 = rvr_pkg::SUM2_W;
    localparam int RW  = rvr_pkg::R_W;
    localparam int SW  = rvr_pkg::SAT_W;
    localparam int OW  = rvr_pkg::OUT_WIDTH;
    localparam int FB  = rvr_pkg::FRAC_BITS;
    localparam int RTW = rvr_pkg::ROT_WIDTH;

    localparam logic signed [SW1-1:0] RND1 = SW1'(1) << (FB - 1);
    localparam logic signed [SW2-1:0] RND2 = SW2'(1) << (FB - 1);
    localparam logic signed [SW-1:0]  OUT_HI = {{(SW - OW + 1){1'b0}}, {(OW - 1){1'b1}}};
    localparam logic signed [SW-1:0]  OUT_LO = {{(SW - OW + 1){1'b1}}, {(OW - 1){1'b0}}};

    function automatic logic signed [QW-1:0] round_q(input logic signed [SW1-1:0] s);
        logic signed [SW1-1:0] sh;
        sh = (s + RND1) >>> FB;
        return $signed(sh[QW-1:0]);
    endfunction

    function automatic logic signed [OW-1:0] round_sat(input logic signed [SW2-1:0] s);
        logic signed [SW2-1:0] sh;
        logic signed [SW-1:0]  e;
        sh = (s + RND2) >>> FB;
        e  = SW'($signed(sh[RW-1:0]));
        if (e > OUT_HI)
        begin
            e = OUT_HI;
        end
        else if (e < OUT_LO)
        begin
            e = OUT_LO;
        end
        return e[OW-1:0];
    endfunction

    logic signed [RTW-1:0] rot_a_reg, rot_b1_reg, rot_b2_reg, rot_b3_reg;
    logic                  cfg_write;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [PW1-1:0] ax_reg, ay_reg, az_reg;
    logic signed [PW1-1:0] xb1_reg, xb2_reg, xb3_reg;
    logic signed [PW1-1:0] yb1_reg, yb2_reg, yb3_reg;
    logic signed [PW1-1:0] zb1_reg, zb2_reg, zb3_reg;

    logic signed [QW-1:0]  qx_next, qy_next, qz_next, t_next;
    logic signed [QW-1:0]  qx_reg, qy_reg, qz_reg, t_reg;

    logic signed [PW2-1:0] aqx_reg, aqy_reg, aqz_reg;
    logic signed [PW2-1:0] qxb1_reg, qxb2_reg, qyb1_reg, qyb3_reg, qzb2_reg, qzb3_reg;
    logic signed [PW2-1:0] tb1_reg, tb2_reg, tb3_reg;

    logic signed [OW-1:0]  out_x_next, out_y_next, out_z_next;
    logic signed [OW-1:0]  out_x_reg, out_y_reg, out_z_reg;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_a_reg  <= rvr_pkg::ROTOR_ONE;
            rot_b1_reg <= '0;
            rot_b2_reg <= '0;
            rot_b3_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (rvr_pkg::reg_index_t'(paddr[3:2]))
                rvr_pkg::REG_SCALAR: rot_a_reg  <= $signed(pwdata[RTW-1:0]);
                rvr_pkg::REG_YZ:     rot_b1_reg <= $signed(pwdata[RTW-1:0]);
                rvr_pkg::REG_ZX:     rot_b2_reg <= $signed(pwdata[RTW-1:0]);
                rvr_pkg::REG_XY:     rot_b3_reg <= $signed(pwdata[RTW-1:0]);
                default:             rot_a_reg  <= rot_a_reg;
            endcase
        end
    end

    always_comb
    begin
        case (rvr_pkg::reg_index_t'(paddr[3:2]))
            rvr_pkg::REG_SCALAR: prdata = rvr_pkg::DATA_WIDTH'(rot_a_reg);
            rvr_pkg::REG_YZ:     prdata = rvr_pkg::DATA_WIDTH'(rot_b1_reg);
            rvr_pkg::REG_ZX:     prdata = rvr_pkg::DATA_WIDTH'(rot_b2_reg);
            rvr_pkg::REG_XY:     prdata = rvr_pkg::DATA_WIDTH'(rot_b3_reg);
            default:             prdata = '0;
        endcase
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // First multiply bank
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            ax_reg  <= PW1'(rot_a_reg) * PW1'(vec_x);
            ay_reg  <= PW1'(rot_a_reg) * PW1'(vec_y);
            az_reg  <= PW1'(rot_a_reg) * PW1'(vec_z);
            xb1_reg <= PW1'(vec_x) * PW1'(rot_b1_reg);
            xb2_reg <= PW1'(vec_x) * PW1'(rot_b2_reg);
            xb3_reg <= PW1'(vec_x) * PW1'(rot_b3_reg);
            yb1_reg <= PW1'(vec_y) * PW1'(rot_b1_reg);
            yb2_reg <= PW1'(vec_y) * PW1'(rot_b2_reg);
            yb3_reg <= PW1'(vec_y) * PW1'(rot_b3_reg);
            zb1_reg <= PW1'(vec_z) * PW1'(rot_b1_reg);
            zb2_reg <= PW1'(vec_z) * PW1'(rot_b2_reg);
            zb3_reg <= PW1'(vec_z) * PW1'(rot_b3_reg);
        end
    end

    always_comb
    begin
        qx_next = round_q(SW1'(ax_reg) + SW1'(yb1_reg) + SW1'(zb2_reg));
        qy_next = round_q(SW1'(ay_reg) - SW1'(xb1_reg) + SW1'(zb3_reg));
        qz_next = round_q(SW1'(az_reg) - SW1'(xb2_reg) - SW1'(yb3_reg));
        t_next  = round_q(SW1'(xb3_reg) - SW1'(yb2_reg) + SW1'(zb1_reg));
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            qz_reg <= qz_next;
            t_reg  <= t_next;
        end
    end

    // Second multiply bank
    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            aqx_reg  <= PW2'(rot_a_reg) * PW2'(qx_reg);
            aqy_reg  <= PW2'(rot_a_reg) * PW2'(qy_reg);
            aqz_reg  <= PW2'(rot_a_reg) * PW2'(qz_reg);
            qxb1_reg <= PW2'(qx_reg) * PW2'(rot_b1_reg);
            qxb2_reg <= PW2'(qx_reg) * PW2'(rot_b2_reg);
            qyb1_reg <= PW2'(qy_reg) * PW2'(rot_b1_reg);
            qyb3_reg <= PW2'(qy_reg) * PW2'(rot_b3_reg);
            qzb2_reg <= PW2'(qz_reg) * PW2'(rot_b2_reg);
            qzb3_reg <= PW2'(qz_reg) * PW2'(rot_b3_reg);
            tb1_reg  <= PW2'(t_reg) * PW2'(rot_b1_reg);
            tb2_reg  <= PW2'(t_reg) * PW2'(rot_b2_reg);
            tb3_reg  <= PW2'(t_reg) * PW2'(rot_b3_reg);
        end
    end

    always_comb
    begin
        out_x_next = round_sat(SW2'(aqx_reg) + SW2'(qyb1_reg) + SW2'(qzb2_reg)
                               + SW2'(tb3_reg));
        out_y_next = round_sat(SW2'(aqy_reg) - SW2'(qxb1_reg) - SW2'(tb2_reg)
                               + SW2'(qzb3_reg));
        out_z_next = round_sat(SW2'(aqz_reg) + SW2'(tb1_reg) - SW2'(qxb2_reg)
                               - SW2'(qyb3_reg));
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg)
        begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
            out_z_reg <= out_z_next;
        end
    end

    assign done  = v4_reg;
    assign out_x = out_x_reg;
    assign out_y = out_y_reg;
    assign out_z = out_z_reg;

endmodule

### sv/rvr_checker.sv
// Port-level checks for the rotor vector rotate core, bound to the top level
`timescale 1ns / 1ps
`include "rotor_vector_rotate_core_assert.svh"

module rvr_checker
(
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  start,
    input logic                                  busy,
    input logic signed [rvr_pkg::VEC_WIDTH-1:0]  vec_x,
    input logic signed [rvr_pkg::VEC_WIDTH-1:0]  vec_y,
    input logic signed [rvr_pkg::VEC_WIDTH-1:0]  vec_z,
    input logic                                  done,
    input logic signed [rvr_pkg::OUT_WIDTH-1:0]  out_x,
    input logic signed [rvr_pkg::OUT_WIDTH-1:0]  out_y,
    input logic signed [rvr_pkg::OUT_WIDTH-1:0]  out_z
);

    logic req;
    logic zero_req;
    logic zero_out;

    assign req      = start && !busy;
    assign zero_req = req && vec_x == 0 && vec_y == 0 && vec_z == 0;
    assign zero_out = out_x == 0 && out_y == 0 && out_z == 0;

    `RVR_ASSERT_DELAY(a_request_done, req, 4, done, "request gave no done")
    `RVR_ASSERT_NOW(a_done_has_request, done, $past(req, rvr_pkg::LATENCY), "done with no request")
    `RVR_ASSERT_DELAY(a_zero_vector, zero_req, 4, zero_out, "zero vector not kept")

endmodule

bind rotor_vector_rotate_core rvr_checker u_rvr_checker (.*);
